### rtl/assert_macros.svh
// Assertion macros used by the top level of the triangle normal block.
// Assertions use the enclosing module's clk and rst_n; SYNTH empties them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ant, con)
`define ASSERT_NXT(lbl, ant, con)
`endif
`endif

### rtl/tun_pkg.sv
// Package for the triangle unit normal block: widths, latencies and payload types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package tun_pkg;

  localparam int COORD_W   = 16;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int MAG_W     = PROD_W + 1;
  localparam int NORM_W    = 30;
  localparam int OUT_FRAC  = 14;
  localparam int OUT_W     = 16;
  localparam int OUT_ONE   = 1 << OUT_FRAC;
  localparam int Q_W       = OUT_FRAC + 1;
  localparam int SQ_W      = 2 * NORM_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int REM_W     = ROOT_W + 3;
  localparam int GRP_W     = 8;
  localparam int NGRP      = (MAG_W + GRP_W - 1) / GRP_W;
  localparam int GLEN_W    = $clog2(GRP_W + 1);
  localparam int BLEN_W    = $clog2(MAG_W + 1);
  localparam int LAT_CROSS = 3;
  localparam int LAT_MERGE = 5 + ROOT_W;
  localparam int LAT_DIV   = Q_W;
  localparam int LAT_PIPE  = LAT_CROSS + LAT_MERGE + LAT_DIV;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } in_req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] norm_x;
    logic signed [OUT_W-1:0] norm_y;
    logic signed [OUT_W-1:0] norm_z;
    logic                    degenerate;
  } out_res_t;

  // scaled magnitudes and flags that ride along with the length computation
  typedef struct packed {
    logic [2:0][NORM_W-1:0] s;
    logic [2:0]             neg;
    logic                   degen;
  } norm_side_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] norm;
    logic                    degen;
  } lane_res_t;

endpackage
`default_nettype wire

### rtl/tun_cross_lane.sv
// One cross product lane: edge vectors, two products and the signed difference.
// Depends on tun_pkg.
`default_nettype none
module tun_cross_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [tun_pkg::COORD_W-1:0]  pj [3],
  input  logic signed [tun_pkg::COORD_W-1:0]  pk [3],
  output logic        [tun_pkg::MAG_W-1:0]    mag,
  output logic                                neg
);

  logic signed [tun_pkg::EDGE_W-1:0] d0j_r, d1j_r, d0k_r, d1k_r;
  logic signed [tun_pkg::PROD_W-1:0] p1_r, p2_r;
  logic signed [tun_pkg::MAG_W-1:0]  cr;
  logic        [tun_pkg::MAG_W-1:0]  mag_r;
  logic                              neg_r;

  assign cr = tun_pkg::MAG_W'(p1_r) - tun_pkg::MAG_W'(p2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      d0j_r <= tun_pkg::EDGE_W'(pj[1]) - tun_pkg::EDGE_W'(pj[0]);
      d1j_r <= tun_pkg::EDGE_W'(pj[2]) - tun_pkg::EDGE_W'(pj[1]);
      d0k_r <= tun_pkg::EDGE_W'(pk[1]) - tun_pkg::EDGE_W'(pk[0]);
      d1k_r <= tun_pkg::EDGE_W'(pk[2]) - tun_pkg::EDGE_W'(pk[1]);
      p1_r  <= d0j_r * d1k_r;
      p2_r  <= d0k_r * d1j_r;
      neg_r <= cr[tun_pkg::MAG_W-1];
      mag_r <= cr[tun_pkg::MAG_W-1] ? tun_pkg::MAG_W'(-cr) : tun_pkg::MAG_W'(cr);
    end
  end

  assign mag = mag_r;
  assign neg = neg_r;

endmodule
`default_nettype wire

### rtl/tun_norm_merge.sv
// Merge stage: common scale from the largest lane magnitude, squares, sum and
// a pipelined integer square root. Depends on tun_pkg.
`default_nettype none
module tun_norm_merge (
  input  logic                             clk,
  input  logic                             en,
  input  logic [tun_pkg::MAG_W-1:0]        mag [3],
  input  logic [2:0]                       neg,
  output logic [tun_pkg::ROOT_W-1:0]       len,
  output tun_pkg::norm_side_t              side
);

  localparam int PAD_W = tun_pkg::NGRP * tun_pkg::GRP_W;

  function automatic logic [tun_pkg::GLEN_W-1:0] grp_len(
    input logic [tun_pkg::GRP_W-1:0] v);
    logic [tun_pkg::GLEN_W-1:0] n;
    n = '0;
    for (int b = 0; b < tun_pkg::GRP_W; b++) begin
      if (v[b]) n = tun_pkg::GLEN_W'(b + 1);
    end
    return n;
  endfunction

  logic [PAD_W-1:0]                 or_pad;
  logic [tun_pkg::NGRP-1:0]         gnz_r, gnz_nxt;
  logic [tun_pkg::GLEN_W-1:0]       glen_r [tun_pkg::NGRP];
  logic [tun_pkg::GLEN_W-1:0]       glen_nxt [tun_pkg::NGRP];
  logic [tun_pkg::MAG_W-1:0]        mag1_r [3];
  logic [tun_pkg::MAG_W-1:0]        mag2_r [3];
  logic [2:0]                       neg1_r, neg2_r;
  logic [tun_pkg::BLEN_W-1:0]       bmax_r, bmax_nxt;
  logic                             degen2_r;
  tun_pkg::norm_side_t              side3_r, side3_nxt, side4_r, side5_r;
  logic [tun_pkg::SQ_W-1:0]         sq_r [3];
  logic [tun_pkg::SUM_W-1:0]        sum_r;

  logic [tun_pkg::REM_W-1:0]        rem_r  [tun_pkg::ROOT_W];
  logic [tun_pkg::ROOT_W-1:0]       root_r [tun_pkg::ROOT_W];
  logic [tun_pkg::SUM_W-1:0]        n_r    [tun_pkg::ROOT_W];
  tun_pkg::norm_side_t              sd_r   [tun_pkg::ROOT_W];

  assign or_pad = {{(PAD_W - tun_pkg::MAG_W){1'b0}}, mag[0] | mag[1] | mag[2]};

  always_comb begin
    for (int g = 0; g < tun_pkg::NGRP; g++) begin
      gnz_nxt[g]  = |or_pad[g*tun_pkg::GRP_W +: tun_pkg::GRP_W];
      glen_nxt[g] = grp_len(or_pad[g*tun_pkg::GRP_W +: tun_pkg::GRP_W]);
    end
  end

  // the bit length of the OR equals the largest bit length of the three
  always_comb begin
    bmax_nxt = '0;
    for (int g = 0; g < tun_pkg::NGRP; g++) begin
      if (gnz_r[g]) begin
        bmax_nxt = tun_pkg::BLEN_W'(g * tun_pkg::GRP_W) + tun_pkg::BLEN_W'(glen_r[g]);
      end
    end
  end

  // scale so the largest magnitude lands in [2^29, 2^30), truncating dropped bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side3_nxt.s[i] = tun_pkg::NORM_W'({mag2_r[i], {tun_pkg::NORM_W{1'b0}}} >> bmax_r);
    end
    side3_nxt.neg   = neg2_r;
    side3_nxt.degen = degen2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gnz_r    <= gnz_nxt;
      glen_r   <= glen_nxt;
      mag1_r   <= mag;
      neg1_r   <= neg;
      bmax_r   <= bmax_nxt;
      degen2_r <= ~|gnz_r;
      mag2_r   <= mag1_r;
      neg2_r   <= neg1_r;
      side3_r  <= side3_nxt;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= side3_r.s[i] * side3_r.s[i];
      end
      side4_r  <= side3_r;
      sum_r    <= tun_pkg::SUM_W'(sq_r[0]) + tun_pkg::SUM_W'(sq_r[1])
                + tun_pkg::SUM_W'(sq_r[2]);
      side5_r  <= side4_r;
    end
  end

  // one result bit per stage, two radicand bits consumed per stage
  for (genvar k = 0; k < tun_pkg::ROOT_W; k++) begin : g_sqrt
    logic [tun_pkg::REM_W-1:0]  rem_in, remx, rem_nxt;
    logic [tun_pkg::ROOT_W-1:0] root_in, root_nxt;
    logic [tun_pkg::SUM_W-1:0]  n_in;
    logic [tun_pkg::ROOT_W+1:0] trial;
    tun_pkg::norm_side_t        side_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = sum_r;
      assign side_in = side5_r;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign n_in    = n_r[k-1];
      assign side_in = sd_r[k-1];
    end

    always_comb begin
      remx  = {rem_in[tun_pkg::REM_W-3:0], n_in[tun_pkg::SUM_W-1 -: 2]};
      trial = {root_in, 2'b01};
      if (remx >= tun_pkg::REM_W'(trial)) begin
        rem_nxt  = remx - tun_pkg::REM_W'(trial);
        root_nxt = {root_in[tun_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = remx;
        root_nxt = {root_in[tun_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        n_r[k]    <= {n_in[tun_pkg::SUM_W-3:0], 2'b00};
        sd_r[k]   <= side_in;
      end
    end
  end

  assign len  = root_r[tun_pkg::ROOT_W-1];
  assign side = sd_r[tun_pkg::ROOT_W-1];

endmodule
`default_nettype wire

### rtl/tun_div_lane.sv
// One divide lane: (s << 14) / len by pipelined restoring division, then sign.
// Depends on tun_pkg.
`default_nettype none
module tun_div_lane (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tun_pkg::NORM_W-1:0]  s,
  input  logic [tun_pkg::ROOT_W-1:0]  len,
  input  logic                        neg,
  input  logic                        degen,
  output tun_pkg::lane_res_t          res
);

  localparam int DR_W = tun_pkg::ROOT_W + 1;

  logic [DR_W-1:0]             rem_r [tun_pkg::Q_W];
  logic [tun_pkg::ROOT_W-1:0]  d_r   [tun_pkg::Q_W];
  logic [tun_pkg::Q_W-1:0]     q_r   [tun_pkg::Q_W];
  logic                        neg_r [tun_pkg::Q_W];
  logic                        dg_r  [tun_pkg::Q_W];
  logic [tun_pkg::OUT_W-1:0]   qx;

  // quotient stays below 2^15 since s never exceeds len
  for (genvar j = 0; j < tun_pkg::Q_W; j++) begin : g_div
    logic [DR_W-1:0]            rem_in, remx, rem_nxt;
    logic [tun_pkg::ROOT_W-1:0] d_in;
    logic [tun_pkg::Q_W-1:0]    q_in;
    logic                       neg_in, dg_in, nbit, qbit;

    if (j == 0) begin : g_first
      assign rem_in = DR_W'(s >> 1);
      assign d_in   = len;
      assign q_in   = '0;
      assign neg_in = neg;
      assign dg_in  = degen;
      assign nbit   = s[0];
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign d_in   = d_r[j-1];
      assign q_in   = q_r[j-1];
      assign neg_in = neg_r[j-1];
      assign dg_in  = dg_r[j-1];
      assign nbit   = 1'b0;
    end

    always_comb begin
      remx = {rem_in[DR_W-2:0], nbit};
      qbit = (remx >= {1'b0, d_in});
      rem_nxt = qbit ? remx - {1'b0, d_in} : remx;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        d_r[j]   <= d_in;
        q_r[j]   <= {q_in[tun_pkg::Q_W-2:0], qbit};
        neg_r[j] <= neg_in;
        dg_r[j]  <= dg_in;
      end
    end
  end

  assign qx = {{(tun_pkg::OUT_W - tun_pkg::Q_W){1'b0}}, q_r[tun_pkg::Q_W-1]};

  always_comb begin
    res.degen = dg_r[tun_pkg::Q_W-1];
    if (dg_r[tun_pkg::Q_W-1]) begin
      res.norm = '0;
    end else if (neg_r[tun_pkg::Q_W-1]) begin
      res.norm = -qx;
    end else begin
      res.norm = qx;
    end
  end

endmodule
`default_nettype wire

### rtl/triangle_unit_normal.sv
// Triangle unit normal: top level, three cross lanes, merge, three divide lanes.
// Depends on tun_pkg, tun_cross_lane, tun_norm_merge, tun_div_lane, assert_macros.svh.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one triangle (three
//   vertices, signed Q4.12). Output channel out_valid / out_stall / out_data
//   carries its unit normal in signed Q1.14 and a degenerate flag, which is
//   set with an all-zero normal when the cross product vanishes.
//   A request is taken on an edge with valid high and stall low.
//   Throughput: one triangle per cycle while the output is not stalled. A request
//   passes the cross product, scale/square/root, divide and output stages to
//   out_valid; the square root and divider are 31-step and 15-step pipelines.
//   All stages advance together; when out_valid is high and out_stall is high
//   the whole pipeline holds and in_stall rises, otherwise a new request is
//   taken every cycle, also while a result is waiting to be taken.
//   Reset clears all valid flags; data registers are not reset.
`default_nettype none
`include "assert_macros.svh"
module triangle_unit_normal (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tun_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tun_pkg::out_res_t out_data
);

  logic                             en;
  logic [tun_pkg::LAT_PIPE-1:0]     vld_r;
  logic                             out_valid_r;
  tun_pkg::out_res_t                out_data_r;
  logic signed [tun_pkg::COORD_W-1:0] ax [3][3];
  logic [tun_pkg::MAG_W-1:0]        mag [3];
  logic [2:0]                       neg;
  logic [tun_pkg::ROOT_W-1:0]       len;
  tun_pkg::norm_side_t              side;
  tun_pkg::lane_res_t               res [3];

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // ax[axis][vertex]
  assign ax[0][0] = in_data.a_x;
  assign ax[0][1] = in_data.b_x;
  assign ax[0][2] = in_data.c_x;
  assign ax[1][0] = in_data.a_y;
  assign ax[1][1] = in_data.b_y;
  assign ax[1][2] = in_data.c_y;
  assign ax[2][0] = in_data.a_z;
  assign ax[2][1] = in_data.b_z;
  assign ax[2][2] = in_data.c_z;

  for (genvar i = 0; i < 3; i++) begin : g_cross
    tun_cross_lane u_cross (
      .clk (clk),
      .en  (en),
      .pj  (ax[(i + 1) % 3]),
      .pk  (ax[(i + 2) % 3]),
      .mag (mag[i]),
      .neg (neg[i])
    );
  end

  tun_norm_merge u_merge (
    .clk  (clk),
    .en   (en),
    .mag  (mag),
    .neg  (neg),
    .len  (len),
    .side (side)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    tun_div_lane u_div (
      .clk   (clk),
      .en    (en),
      .s     (side.s[i]),
      .len   (len),
      .neg   (side.neg[i]),
      .degen (side.degen),
      .res   (res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[tun_pkg::LAT_PIPE-2:0], in_valid};
      out_valid_r <= vld_r[tun_pkg::LAT_PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.norm_x     <= res[0].norm;
      out_data_r.norm_y     <= res[1].norm;
      out_data_r.norm_z     <= res[2].norm;
      out_data_r.degenerate <= res[0].degen;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)
  `ASSERT_NXT(a_accept_enters, in_valid && !in_stall, vld_r[0])
  `ASSERT_IMP(a_degen_zero, out_valid && out_data.degenerate, (out_data.norm_x == '0) && (out_data.norm_y == '0) && (out_data.norm_z == '0))
  `ASSERT_IMP(a_x_range, out_valid, (out_data.norm_x <= tun_pkg::OUT_ONE) && (out_data.norm_x >= -tun_pkg::OUT_ONE))
  `ASSERT_IMP(a_z_range, out_valid, (out_data.norm_z <= tun_pkg::OUT_ONE) && (out_data.norm_z >= -tun_pkg::OUT_ONE))

endmodule
`default_nettype wire
